FILE: design/cid_pkg.sv
// ----------------------------------------------------------------------------
// cid_pkg
// Shared types and prefix constants for the compressed integer decoder.
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 3;

  localparam logic [ByteW-1:0] BYTE_NEG_ONE  = 8'hFF;
  localparam logic [ByteW-1:0] BYTE_RAW_LE   = 8'hF0;
  localparam logic [ByteW-1:0] MASK_TWO_BYTE = 8'h3F;
  localparam logic [ByteW-1:0] MASK_FOUR_BYTE = 8'h1F;

  localparam logic [1:0] PFX_TWO_BYTE  = 2'b10;
  localparam logic [2:0] PFX_FOUR_BYTE = 3'b110;

  localparam logic [CountW-1:0] CNT_IDLE     = 3'd0;
  localparam logic [CountW-1:0] CNT_TWO_BYTE = 3'd1;
  localparam logic [CountW-1:0] CNT_FOUR_BE  = 3'd3;
  localparam logic [CountW-1:0] CNT_FOUR_LE  = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             signed_mode;
    logic             buffer_end;
  } beat_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ok;
  } result_t;

endpackage

FILE: design/cid_in_reg.sv
// ----------------------------------------------------------------------------
// cid_in_reg
// Input register stage: captures one beat and holds it until the decoder
// consumes it.
// ----------------------------------------------------------------------------
module cid_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cid_pkg::beat_t in_beat,
  output logic           beat_valid,
  input  logic           beat_take,
  output cid_pkg::beat_t beat
);

  logic           valid_r;
  logic           valid_nxt;
  cid_pkg::beat_t beat_r;

  assign in_ready   = !valid_r || beat_take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (beat_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

FILE: design/cid_decode.sv
// ----------------------------------------------------------------------------
// cid_decode
// Decode state and next-state logic: while fire is high, one registered beat
// per cycle updates the byte count and accumulator and may produce one result.
// ----------------------------------------------------------------------------
module cid_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  cid_pkg::beat_t   beat,
  output logic             emit,
  output cid_pkg::result_t result
);

  logic [cid_pkg::CountW-1:0] bytes_left_r;
  logic [cid_pkg::CountW-1:0] bytes_left_nxt;
  logic [cid_pkg::ValueW-1:0] acc_r;
  logic [cid_pkg::ValueW-1:0] acc_nxt;
  logic                       le_r;
  logic                       le_nxt;

  logic [cid_pkg::ByteW-1:0]  b;
  logic [cid_pkg::ValueW-1:0] acc_upd;
  logic [cid_pkg::ValueW-1:0] b_ext;
  logic [1:0]                 pos;
  logic [cid_pkg::CountW-1:0] cnt_dec;
  logic                       multi;

  assign b       = beat.data_byte;
  assign b_ext   = {{(cid_pkg::ValueW-cid_pkg::ByteW){1'b0}}, b};
  assign pos     = 2'(cid_pkg::CNT_FOUR_LE - bytes_left_r);
  assign cnt_dec = bytes_left_r - 3'd1;

  always_comb begin
    case (pos)
      2'd0:    acc_upd = acc_r | b_ext;
      2'd1:    acc_upd = acc_r | (b_ext << 8);
      2'd2:    acc_upd = acc_r | (b_ext << 16);
      2'd3:    acc_upd = acc_r | (b_ext << 24);
      default: acc_upd = acc_r;
    endcase
    if (!le_r) begin
      acc_upd = {acc_r[cid_pkg::ValueW-cid_pkg::ByteW-1:0], b};
    end
  end

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    le_nxt         = le_r;
    emit           = 1'b0;
    result         = '{value: '0, ok: 1'b0};
    multi          = 1'b0;
    if (bytes_left_r == cid_pkg::CNT_IDLE) begin
      bytes_left_nxt = cid_pkg::CNT_IDLE;
      acc_nxt        = '0;
      le_nxt         = 1'b0;
      if (beat.signed_mode && b == cid_pkg::BYTE_NEG_ONE) begin
        emit   = 1'b1;
        result = '{value: '1, ok: 1'b1};
      end else if (!b[7]) begin
        emit   = 1'b1;
        result = '{value: b_ext, ok: 1'b1};
      end else if (b[7:6] == cid_pkg::PFX_TWO_BYTE) begin
        multi          = 1'b1;
        acc_nxt        = b_ext & 32'(cid_pkg::MASK_TWO_BYTE);
        bytes_left_nxt = cid_pkg::CNT_TWO_BYTE;
      end else if (b[7:5] == cid_pkg::PFX_FOUR_BYTE) begin
        multi          = 1'b1;
        acc_nxt        = b_ext & 32'(cid_pkg::MASK_FOUR_BYTE);
        bytes_left_nxt = cid_pkg::CNT_FOUR_BE;
      end else if (b == cid_pkg::BYTE_RAW_LE) begin
        multi          = 1'b1;
        le_nxt         = 1'b1;
        bytes_left_nxt = cid_pkg::CNT_FOUR_LE;
      end else begin
        emit = 1'b1;
      end
      if (multi && beat.buffer_end) begin
        emit           = 1'b1;
        bytes_left_nxt = cid_pkg::CNT_IDLE;
        acc_nxt        = '0;
        le_nxt         = 1'b0;
      end
    end else begin
      acc_nxt        = acc_upd;
      bytes_left_nxt = cnt_dec;
      if (cnt_dec == cid_pkg::CNT_IDLE) begin
        emit    = 1'b1;
        result  = '{value: acc_upd, ok: 1'b1};
        acc_nxt = '0;
        le_nxt  = 1'b0;
      end else if (beat.buffer_end) begin
        emit           = 1'b1;
        bytes_left_nxt = cid_pkg::CNT_IDLE;
        acc_nxt        = '0;
        le_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= cid_pkg::CNT_IDLE;
      acc_r        <= '0;
      le_r         <= 1'b0;
    end else if (fire) begin
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
      le_r         <= le_nxt;
    end
  end

  a_le_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    le_r |-> bytes_left_r != cid_pkg::CNT_IDLE)
    else $error("raw form flag set with no bytes pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= cid_pkg::CNT_FOUR_LE)
    else $error("byte count out of range");

  a_last_byte_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && bytes_left_r == cid_pkg::CNT_TWO_BYTE |=> bytes_left_r == cid_pkg::CNT_IDLE)
    else $error("count did not return to idle after final byte");

endmodule

FILE: design/cid_out_reg.sv
// ----------------------------------------------------------------------------
// cid_out_reg
// Result register: holds one decoded value until the receiver takes it.
// ----------------------------------------------------------------------------
module cid_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  cid_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output cid_pkg::result_t out_res
);

  logic             valid_r;
  logic             valid_nxt;
  cid_pkg::result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_r.ok |-> res_r.value == '0)
    else $error("failed result carries a nonzero value");

endmodule

FILE: design/compressed_int_decoder.sv
// ----------------------------------------------------------------------------
// compressed_int_decoder
// Decodes variable-length compressed integers from a byte stream.
// ----------------------------------------------------------------------------
// Input beats carry one byte of the encoded buffer in in_tdata, the signed
// mode flag in in_tuser (looked at on a first byte only) and the end of the
// buffer in in_tlast. A result beat carries the 32-bit value in out_tdata
// and the ok flag in out_tuser; it appears when a value completes, when a
// first byte has a bad prefix, or when the buffer ends early (ok low,
// value zero). Beats that continue a value give no result.
// One beat is taken every cycle while a stalled receiver does not hold the
// result register full. A beat passes an input register, the decode logic
// and a result register; the byte count and accumulator are updated as
// each beat leaves the input register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to awaiting a first byte.
// While the receiver holds out_tready low, the result register holds its
// beat and the input register can still take one more beat; after that
// in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module compressed_int_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] signed_mode
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic        out_tuser   // [0] ok
);

  cid_pkg::beat_t   in_beat;
  cid_pkg::beat_t   beat;
  logic             beat_valid;
  logic             res_ready;
  logic             fire;
  logic             emit;
  cid_pkg::result_t dec_res;
  cid_pkg::result_t out_res;

  assign in_beat = '{data_byte: in_tdata, signed_mode: in_tuser, buffer_end: in_tlast};
  assign fire    = beat_valid && res_ready;

  cid_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_beat    (in_beat),
    .beat_valid (beat_valid),
    .beat_take  (fire),
    .beat       (beat)
  );

  cid_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .beat   (beat),
    .emit   (emit),
    .result (dec_res)
  );

  cid_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (fire && emit),
    .res_ready (res_ready),
    .res       (dec_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = out_res.ok;

endmodule
